[rtl/pcc_pkg.sv]
// Package for the palette color cycler: payload structs, state type,
// controller command and status structs, register indexes and reset values.
// Has no dependencies; every other file of the block uses it by scoped names.
package pcc_pkg;

   localparam int RANGE_COUNT   = 3;
   localparam int MAX_RANGE_LEN = 6;

   localparam int SLOT_W     = 5;
   localparam int LEN_W      = 3;
   localparam int HEAD_W     = 3;
   localparam int RATE_W     = 13;
   localparam int SLOTS_W    = 30;
   localparam int LENS_W     = 9;
   localparam int ACC_W      = 15;
   localparam int COLOR_W    = 12;
   localparam int RANGE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   // Input commands.
   localparam logic PCC_CMD_TICK  = 1'b0;
   localparam logic PCC_CMD_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_RATE0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_RATE1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_RATE2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_SLOTS0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_SLOTS1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_SLOTS2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] PCC_CSR_LENS   = 3'd6;

   // Register reset values.
   localparam logic [RATE_W-1:0]  PCC_RATE0_RESET  = 13'd2560;
   localparam logic [RATE_W-1:0]  PCC_RATE1_RESET  = 13'd2560;
   localparam logic [RATE_W-1:0]  PCC_RATE2_RESET  = 13'd1664;
   localparam logic [SLOTS_W-1:0] PCC_SLOTS0_RESET = 30'd9671777;
   localparam logic [SLOTS_W-1:0] PCC_SLOTS1_RESET = 30'd10754178;
   localparam logic [SLOTS_W-1:0] PCC_SLOTS2_RESET = 30'd416757131;
   localparam logic [LENS_W-1:0]  PCC_LENS_RESET   = 9'd429;

   typedef struct packed {
      logic               command;
      logic [SLOT_W-1:0]  palette_index;
      logic [COLOR_W-1:0] color;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  color_register;
      logic [COLOR_W-1:0] color_value;
      logic [RANGE_W-1:0] range_number;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      PCC_IDLE,
      PCC_SCAN,
      PCC_READ,
      PCC_EMIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic tick_load;
      logic pal_write;
      logic range_start;
      logic range_next;
      logic emit;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic fire_cur;
      logic last_range;
      logic last_slot;
      logic slot_free;
   } ctl_sts_type;

endpackage

[rtl/pcc_ctl.sv]
// Controller state machine of the palette color cycler.
// Depends on pcc_pkg for the state type and the command and status structs.
module pcc_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   input  pcc_pkg::ctl_sts_type sts,
   output logic                 req_stall,
   output pcc_pkg::ctl_cmd_type cmd
);

   pcc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcc_pkg::PCC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcc_pkg::PCC_IDLE: begin
            if (req_valid && req_command == pcc_pkg::PCC_CMD_TICK) begin
               state_in = pcc_pkg::PCC_SCAN;
            end
         end
         pcc_pkg::PCC_SCAN: begin
            if (sts.fire_cur) begin
               state_in = pcc_pkg::PCC_READ;
            end else if (sts.last_range) begin
               state_in = pcc_pkg::PCC_IDLE;
            end
         end
         pcc_pkg::PCC_READ: begin
            state_in = pcc_pkg::PCC_EMIT;
         end
         pcc_pkg::PCC_EMIT: begin
            if (sts.slot_free) begin
               if (!sts.last_slot) begin
                  state_in = pcc_pkg::PCC_READ;
               end else if (sts.last_range) begin
                  state_in = pcc_pkg::PCC_IDLE;
               end else begin
                  state_in = pcc_pkg::PCC_SCAN;
               end
            end
         end
         default: state_in = pcc_pkg::PCC_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pcc_pkg::PCC_IDLE: begin
            req_stall     = 1'b0;
            cmd.tick_load = req_valid && req_command == pcc_pkg::PCC_CMD_TICK;
            cmd.pal_write = req_valid && req_command == pcc_pkg::PCC_CMD_WRITE;
         end
         pcc_pkg::PCC_SCAN: begin
            cmd.range_start = sts.fire_cur;
            cmd.range_next  = !sts.fire_cur && !sts.last_range;
         end
         pcc_pkg::PCC_READ: begin
         end
         pcc_pkg::PCC_EMIT: begin
            cmd.emit       = sts.slot_free;
            cmd.range_next = sts.slot_free && sts.last_slot && !sts.last_range;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/pcc_datapath.sv]
// Datapath of the palette color cycler: configuration registers, step
// accumulators, head positions, palette memory and the result register.
// Depends on pcc_pkg; driven by pcc_ctl through command and status structs.
module pcc_datapath #(
   parameter int PALETTE_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pcc_pkg::req_type                  req_payload,
   input  pcc_pkg::ctl_cmd_type              cmd,
   output pcc_pkg::ctl_sts_type              sts,
   input  logic                              csr_valid,
   input  logic [pcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output pcc_pkg::rsp_type                  rsp_payload
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int IW = (AW > pcc_pkg::SLOT_W) ? AW : pcc_pkg::SLOT_W;
   localparam int RC = pcc_pkg::RANGE_COUNT;
   localparam int ML = pcc_pkg::MAX_RANGE_LEN;

   // Remainder of a small head value by a nonzero length.
   function automatic logic [pcc_pkg::HEAD_W-1:0] mod_small(
      input logic [pcc_pkg::HEAD_W-1:0] h,
      input logic [pcc_pkg::LEN_W-1:0]  l
   );
      logic [pcc_pkg::HEAD_W-1:0] v;
      v = h;
      for (int k = 0; k < 7; k++) begin
         if (v >= l) begin
            v = v - l;
         end
      end
      return v;
   endfunction

   logic [pcc_pkg::RATE_W-1:0]  rate_ff  [RC];
   logic [pcc_pkg::RATE_W-1:0]  rate_in  [RC];
   logic [pcc_pkg::SLOTS_W-1:0] slots_ff [RC];
   logic [pcc_pkg::SLOTS_W-1:0] slots_in [RC];
   logic [pcc_pkg::LENS_W-1:0]  lens_ff, lens_in;
   logic [pcc_pkg::ACC_W-1:0]   acc_ff   [RC];
   logic [pcc_pkg::ACC_W-1:0]   acc_in   [RC];
   logic [pcc_pkg::HEAD_W-1:0]  head_ff  [RC];
   logic [pcc_pkg::HEAD_W-1:0]  head_in  [RC];
   logic [RC-1:0]               fire_ff, fire_in;
   logic [pcc_pkg::RANGE_W-1:0] r_ff, r_in;
   logic [pcc_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [pcc_pkg::HEAD_W-1:0]  hm_ff, hm_in;
   logic [pcc_pkg::HEAD_W-1:0]  i_ff, i_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pcc_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;

   logic [pcc_pkg::COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
   logic [pcc_pkg::COLOR_W-1:0] rdata_ff;
   logic                        rd_ok_ff;

   logic [pcc_pkg::LEN_W-1:0]   len_all  [RC];
   logic [pcc_pkg::ACC_W-1:0]   sum_all  [RC];
   logic [RC-1:0]               fire_now;
   logic [pcc_pkg::SLOT_W-1:0]  slot_arr [RC][ML];
   logic [pcc_pkg::LEN_W-1:0]   len_cur;
   logic [pcc_pkg::HEAD_W-1:0]  hm_now, hm_next;
   logic [pcc_pkg::HEAD_W:0]    src_raw;
   logic [pcc_pkg::HEAD_W-1:0]  src;
   logic [pcc_pkg::SLOT_W-1:0]  rd_slot;
   logic [IW-1:0]               rd_ext, wr_ext;
   logic                        rd_ok, wr_ok;
   logic                        fire_above;

   // Per-range decode of lengths, slot indices and the accumulator sum.
   always_comb begin
      for (int r = 0; r < RC; r++) begin
         len_all[r] = lens_ff[pcc_pkg::LEN_W*r +: pcc_pkg::LEN_W];
         if (len_all[r] > pcc_pkg::LEN_W'(ML)) begin
            len_all[r] = pcc_pkg::LEN_W'(ML);
         end
         sum_all[r]  = acc_ff[r] + pcc_pkg::ACC_W'({rate_ff[r], 1'b0});
         fire_now[r] = (len_all[r] != '0) && sum_all[r][pcc_pkg::ACC_W-1];
         for (int k = 0; k < ML; k++) begin
            slot_arr[r][k] = slots_ff[r][pcc_pkg::SLOT_W*k +: pcc_pkg::SLOT_W];
         end
      end
   end

   assign len_cur = len_all[r_ff];
   assign hm_now  = mod_small(head_ff[r_ff], len_cur);
   assign hm_next = (pcc_pkg::LEN_W'(hm_now + 1'b1) == len_cur) ? '0 : hm_now + 1'b1;

   // Source position (head + len - 1 - i) mod len; the sum stays below 2*len.
   assign src_raw = {1'b0, hm_ff} + {1'b0, len_ff} - 1'b1 - {1'b0, i_ff};
   assign src     = (src_raw >= {1'b0, len_ff}) ?
                    pcc_pkg::HEAD_W'(src_raw - {1'b0, len_ff}) :
                    src_raw[pcc_pkg::HEAD_W-1:0];
   assign rd_slot = slot_arr[r_ff][src];

   assign rd_ext = IW'(rd_slot);
   assign wr_ext = IW'(req_payload.palette_index);
   assign rd_ok  = 32'(rd_slot) < PALETTE_DEPTH;
   assign wr_ok  = 32'(req_payload.palette_index) < PALETTE_DEPTH;

   always_comb begin
      fire_above = 1'b0;
      for (int k = 0; k < RC; k++) begin
         if (k > int'(r_ff) && fire_ff[k]) begin
            fire_above = 1'b1;
         end
      end
   end

   always_comb begin
      sts.fire_cur   = fire_ff[r_ff];
      sts.last_range = (r_ff == pcc_pkg::RANGE_W'(RC - 1));
      sts.last_slot  = (i_ff == '0);
      sts.slot_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      rate_in  = rate_ff;
      slots_in = slots_ff;
      lens_in  = lens_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pcc_pkg::PCC_CSR_RATE0:  rate_in[0]  = csr_data[pcc_pkg::RATE_W-1:0];
            pcc_pkg::PCC_CSR_RATE1:  rate_in[1]  = csr_data[pcc_pkg::RATE_W-1:0];
            pcc_pkg::PCC_CSR_RATE2:  rate_in[2]  = csr_data[pcc_pkg::RATE_W-1:0];
            pcc_pkg::PCC_CSR_SLOTS0: slots_in[0] = csr_data;
            pcc_pkg::PCC_CSR_SLOTS1: slots_in[1] = csr_data;
            pcc_pkg::PCC_CSR_SLOTS2: slots_in[2] = csr_data;
            pcc_pkg::PCC_CSR_LENS:   lens_in     = csr_data[pcc_pkg::LENS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      head_in = head_ff;
      fire_in = fire_ff;
      r_in    = r_ff;
      len_in  = len_ff;
      hm_in   = hm_ff;
      i_in    = i_ff;
      if (cmd.tick_load) begin
         // Every enabled range advances now; a firing range loses one step unit.
         for (int r = 0; r < RC; r++) begin
            if (len_all[r] != '0) begin
               acc_in[r] = {1'b0, sum_all[r][pcc_pkg::ACC_W-2:0]};
            end
         end
         fire_in = fire_now;
         r_in    = '0;
      end
      if (cmd.range_start) begin
         len_in        = len_cur;
         hm_in         = hm_now;
         i_in          = pcc_pkg::HEAD_W'(len_cur - 1'b1);
         head_in[r_ff] = hm_next;
      end
      if (cmd.emit) begin
         i_in = i_ff - 1'b1;
      end
      if (cmd.range_next) begin
         r_in = r_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in                  = 1'b1;
         rsp_payload_in.color_register = slot_arr[r_ff][i_ff];
         rsp_payload_in.color_value    = rd_ok_ff ? rdata_ff : '0;
         rsp_payload_in.range_number   = r_ff;
         rsp_payload_in.last           = (i_ff == '0) && !fire_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff[0]   <= pcc_pkg::PCC_RATE0_RESET;
         rate_ff[1]   <= pcc_pkg::PCC_RATE1_RESET;
         rate_ff[2]   <= pcc_pkg::PCC_RATE2_RESET;
         slots_ff[0]  <= pcc_pkg::PCC_SLOTS0_RESET;
         slots_ff[1]  <= pcc_pkg::PCC_SLOTS1_RESET;
         slots_ff[2]  <= pcc_pkg::PCC_SLOTS2_RESET;
         lens_ff      <= pcc_pkg::PCC_LENS_RESET;
         for (int r = 0; r < RC; r++) begin
            acc_ff[r]  <= '0;
            head_ff[r] <= '0;
         end
         fire_ff      <= '0;
         r_ff         <= '0;
         len_ff       <= '0;
         hm_ff        <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         slots_ff     <= slots_in;
         lens_ff      <= lens_in;
         acc_ff       <= acc_in;
         head_ff      <= head_in;
         fire_ff      <= fire_in;
         r_ff         <= r_in;
         len_ff       <= len_in;
         hm_ff        <= hm_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // Palette memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.pal_write && wr_ok) begin
         pal_mem[wr_ext[AW-1:0]] <= req_payload.color;
      end
      rdata_ff <= pal_mem[rd_ext[AW-1:0]];
      rd_ok_ff <= rd_ok;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/palette_color_cycler.sv]
// Top level of the palette color cycler: joins the controller and datapath.
// Depends on pcc_pkg, pcc_ctl and pcc_datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  pcc_pkg::req_type
//   rsp_      out        rsp_valid / rsp_stall  pcc_pkg::rsp_type
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// A palette write is taken while idle and leaves the block idle. A tick
// scans the ranges in turn; each register rewrite passes through a read
// state and then an emit state, as the palette read port is registered.
// Reset is synchronous and active high; it restores the configuration
// defaults and clears accumulators and heads.
// The palette holds no defined contents until it is written.
// A stall on rsp_ holds the result register and pauses the walk.
//
// The block works on one item at a time. A tick first adds twice each
// enabled range's rate to its accumulator and notes which ranges cross one
// step unit, so the final transfer of the tick can be flagged as last before
// the later ranges are walked. Each firing range then rewrites its color
// registers from the highest slot down, reading the palette at the rotated
// slot position, and its head advances by one. The result register sits
// between the walk and the rsp_ channel, so the block returns to idle and
// accepts the next item while the final transfer of a tick still waits.
// Configuration writes are always ready and are meant to be issued only
// while the block is idle.
module palette_color_cycler #(
   parameter int PALETTE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pcc_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pcc_pkg::rsp_type               rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcc_pkg::CSR_DATA_W-1:0] csr_data
);

   pcc_pkg::ctl_cmd_type cmd;
   pcc_pkg::ctl_sts_type sts;

   // Registers are plain flops, so a write can land in any cycle.
   assign csr_ready = 1'b1;

   pcc_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .sts         (sts),
      .req_stall   (req_stall),
      .cmd         (cmd)
   );

   pcc_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/pcc_checker.sv]
// Port-level checks for the palette color cycler, bound to its top level.
// Depends on pcc_pkg and palette_color_cycler.
module pcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pcc_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pcc_pkg::rsp_type rsp_payload
);

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // An accepted tick always makes the block busy in the cycle after it.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.command == pcc_pkg::PCC_CMD_TICK
      |=> req_stall)
      else $error("tick transfer did not start a walk");

   // A palette write finishes in its own cycle.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.command == pcc_pkg::PCC_CMD_WRITE
      |=> !req_stall)
      else $error("palette write left the block busy");

   // While idle, a pending result can only be the final one of a tick.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !req_stall |-> rsp_payload.last)
      else $error("block idle with a non-final result pending");

   // Results name only existing ranges.
   a_range_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.range_number != 2'd3)
      else $error("result names a range that does not exist");

endmodule

bind palette_color_cycler pcc_checker u_pcc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[tb/sv/tb_palette_color_cycler.sv]
`timescale 1ns / 1ps
// Self-checking testbench for palette_color_cycler: directed tests, backpressure, random traffic.
// Depends on pcc_pkg and palette_color_cycler. It keeps its own copy of the ranges, the
// accumulators, the heads and the palette, and checks every color register rewrite.
module tb_palette_color_cycler;

   localparam int PALETTE_DEPTH  = 32;
   localparam int STEP_UNIT      = 1 << 14;
   localparam int DRAIN_CYCLES   = 60;    // well past the longest tick
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 352;
   localparam logic [pcc_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   pcc_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   pcc_pkg::rsp_type               rsp_payload;
   logic                           csr_valid   = 1'b0;
   logic                           csr_ready;
   logic [pcc_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [pcc_pkg::CSR_DATA_W-1:0] csr_data    = '0;

   // Shadow of the block: configuration, per-range state and the palette store.
   logic [pcc_pkg::RATE_W-1:0]  rate_cfg [pcc_pkg::RANGE_COUNT];
   logic [pcc_pkg::SLOTS_W-1:0] slots_cfg[pcc_pkg::RANGE_COUNT];
   logic [pcc_pkg::LENS_W-1:0]  lens_cfg;
   logic [pcc_pkg::ACC_W-1:0]   step_acc [pcc_pkg::RANGE_COUNT];
   logic [pcc_pkg::HEAD_W-1:0]  head_pos [pcc_pkg::RANGE_COUNT];
   logic [pcc_pkg::COLOR_W-1:0] palette_shadow[PALETTE_DEPTH];

   pcc_pkg::rsp_type expected_writes[$];
   int      mismatches   = 0;
   int      items_sent   = 0;
   int      quiet_cycles = 0;
   int      req_idle_pct = 0;
   int      rsp_idle_pct = 0;
   logic    rsp_hold_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   palette_color_cycler #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Mostly short gaps, now and then a long one; a percentage of zero gives a clean stretch.
   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [pcc_pkg::LENS_W-1:0] pack_lengths(input int l0, input int l1,
                                                               input int l2);
      return pcc_pkg::LENS_W'(l0 | (l1 << pcc_pkg::LEN_W) | (l2 << (2 * pcc_pkg::LEN_W)));
   endfunction

   // Works out the rewrites that one accepted item causes and queues them in order.
   // A write only updates the palette shadow. A tick advances every enabled range;
   // a range that crosses one step unit walks its slots from the top down, reading
   // the palette at the slot rotated by its head, and then moves the head on.
   function automatic void predict_rewrites(input pcc_pkg::req_type item);
      pcc_pkg::rsp_type burst[$];
      pcc_pkg::rsp_type rw;
      int unsigned len;
      int unsigned hd;
      int unsigned src;
      int unsigned total;
      if (item.command == pcc_pkg::PCC_CMD_WRITE) begin
         palette_shadow[item.palette_index] = item.color;
         return;
      end
      for (int r = 0; r < pcc_pkg::RANGE_COUNT; r++) begin
         len = lens_cfg[pcc_pkg::LEN_W*r +: pcc_pkg::LEN_W];
         // A length of seven behaves as the longest legal range.
         if (len > pcc_pkg::MAX_RANGE_LEN)
            len = pcc_pkg::MAX_RANGE_LEN;
         // A disabled range keeps its accumulator and head untouched.
         if (len == 0)
            continue;
         total = step_acc[r] + 2 * rate_cfg[r];
         if (total < STEP_UNIT) begin
            step_acc[r] = pcc_pkg::ACC_W'(total);
            continue;
         end
         // The head may be stale after the length was shortened.
         hd = head_pos[r] % len;
         for (int i = len - 1; i >= 0; i--) begin
            src = (hd + len - 1 - i) % len;
            rw.color_register = slots_cfg[r][pcc_pkg::SLOT_W*i +: pcc_pkg::SLOT_W];
            rw.color_value    =
               palette_shadow[slots_cfg[r][pcc_pkg::SLOT_W*src +: pcc_pkg::SLOT_W]];
            rw.range_number   = pcc_pkg::RANGE_W'(r);
            rw.last           = 1'b0;
            burst.push_back(rw);
         end
         step_acc[r] = pcc_pkg::ACC_W'(total - STEP_UNIT);
         head_pos[r] = pcc_pkg::HEAD_W'((hd + 1) % len);
      end
      if (burst.size() > 0)
         burst[burst.size()-1].last = 1'b1;
      foreach (burst[k])
         expected_writes.push_back(burst[k]);
   endfunction

   // Offers one item after a random gap and holds it until the transfer. The valid
   // stays high afterwards so that back-to-back items need no second assignment.
   task automatic send_req(input pcc_pkg::req_type item);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_rewrites(item);
   endtask

   task automatic send_tick();
      pcc_pkg::req_type item;
      // The unused fields of a tick carry noise.
      item.command       = pcc_pkg::PCC_CMD_TICK;
      item.palette_index = pcc_pkg::SLOT_W'($urandom);
      item.color         = pcc_pkg::COLOR_W'($urandom);
      send_req(item);
   endtask

   task automatic send_write(input int idx, input int color);
      pcc_pkg::req_type item;
      item.command       = pcc_pkg::PCC_CMD_WRITE;
      item.palette_index = pcc_pkg::SLOT_W'(idx);
      item.color         = pcc_pkg::COLOR_W'(color);
      send_req(item);
   endtask

   // Drops the request, waits for every queued rewrite, then lets a tick that makes
   // no result run out before anything is reconfigured.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pcc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pcc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pcc_pkg::PCC_CSR_RATE0:  rate_cfg[0]  = data[pcc_pkg::RATE_W-1:0];
         pcc_pkg::PCC_CSR_RATE1:  rate_cfg[1]  = data[pcc_pkg::RATE_W-1:0];
         pcc_pkg::PCC_CSR_RATE2:  rate_cfg[2]  = data[pcc_pkg::RATE_W-1:0];
         pcc_pkg::PCC_CSR_SLOTS0: slots_cfg[0] = data[pcc_pkg::SLOTS_W-1:0];
         pcc_pkg::PCC_CSR_SLOTS1: slots_cfg[1] = data[pcc_pkg::SLOTS_W-1:0];
         pcc_pkg::PCC_CSR_SLOTS2: slots_cfg[2] = data[pcc_pkg::SLOTS_W-1:0];
         pcc_pkg::PCC_CSR_LENS:   lens_cfg     = data[pcc_pkg::LENS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [pcc_pkg::RATE_W-1:0]  r0,
                               input logic [pcc_pkg::RATE_W-1:0]  r1,
                               input logic [pcc_pkg::RATE_W-1:0]  r2,
                               input logic [pcc_pkg::SLOTS_W-1:0] s0,
                               input logic [pcc_pkg::SLOTS_W-1:0] s1,
                               input logic [pcc_pkg::SLOTS_W-1:0] s2,
                               input logic [pcc_pkg::LENS_W-1:0]  lens);
      wait_idle();
      write_csr(pcc_pkg::PCC_CSR_RATE0, pcc_pkg::CSR_DATA_W'(r0));
      write_csr(pcc_pkg::PCC_CSR_RATE1, pcc_pkg::CSR_DATA_W'(r1));
      write_csr(pcc_pkg::PCC_CSR_RATE2, pcc_pkg::CSR_DATA_W'(r2));
      write_csr(pcc_pkg::PCC_CSR_SLOTS0, s0);
      write_csr(pcc_pkg::PCC_CSR_SLOTS1, s1);
      write_csr(pcc_pkg::PCC_CSR_SLOTS2, s2);
      write_csr(pcc_pkg::PCC_CSR_LENS, pcc_pkg::CSR_DATA_W'(lens));
      csr_valid <= 1'b0;
   endtask

   // Reset defaults: load only the entries the default ranges read, plus both
   // ends of the palette, then tick until every range has fired at least once.
   task automatic test_reset_defaults();
      send_write(0, 12'h000);
      send_write(31, 12'hFFF);
      send_write(1, 12'hAAA);
      send_write(2, 12'h555);
      send_write(3, 12'hFFF);
      send_write(4, 12'h000);
      for (int i = 5; i <= 14; i++)
         send_write(i, $urandom_range(0, 4095));
      repeat (8) send_tick();
   endtask

   // The rest of the palette gets random colors, so any slot may be read from now on.
   task automatic test_palette_fill();
      req_idle_pct = 30;
      for (int i = 15; i <= 30; i++)
         send_write(i, $urandom_range(0, 4095));
      req_idle_pct = 0;
   endtask

   task automatic test_special_cases();
      logic [pcc_pkg::SLOTS_W-1:0] s0, s1, s2;
      s0 = pcc_pkg::SLOTS_W'($urandom);
      s1 = pcc_pkg::SLOTS_W'($urandom);
      s2 = pcc_pkg::SLOTS_W'($urandom);
      // Top rate with every length field at seven, which saturates to six.
      apply_config(13'd8191, 13'd8191, 13'd8191, s0, s1, s2, 9'h1FF);
      repeat (4) send_tick();
      // Shorter ranges while the heads still point further on.
      apply_config(13'd8191, 13'd8191, 13'd8191, s0, s1, s2, pack_lengths(1, 2, 3));
      repeat (3) send_tick();
      // Rate zero never fires; range one is switched off and must keep its state.
      apply_config(13'd0, 13'd8191, 13'd4096, s0, s1, s2, pack_lengths(6, 0, 4));
      repeat (4) send_tick();
      apply_config(13'd0, 13'd8191, 13'd4096, s0, s1, s2, pack_lengths(6, 6, 6));
      repeat (3) send_tick();
      // A write to the unused register index must change nothing.
      wait_idle();
      write_csr(CSR_UNUSED_IDX, pcc_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      repeat (2) send_tick();
   endtask

   // The receiver holds off for a long stretch while ticks keep coming, so the
   // result register fills and the block has to stall its input.
   task automatic test_backpressure();
      apply_config(13'd8191, 13'd8191, 13'd8191, pcc_pkg::SLOTS_W'($urandom),
                   pcc_pkg::SLOTS_W'($urandom), pcc_pkg::SLOTS_W'($urandom),
                   pack_lengths(6, 6, 6));
      req_idle_pct = 0;
      rsp_hold_req = 1'b1;
      repeat (12) send_tick();
   endtask

   task automatic test_random_traffic();
      logic [pcc_pkg::RATE_W-1:0] rates[pcc_pkg::RANGE_COUNT];
      int lens[pcc_pkg::RANGE_COUNT];
      int stop_at;
      int phase_items;
      int pick;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         for (int r = 0; r < pcc_pkg::RANGE_COUNT; r++) begin
            pick = $urandom_range(0, 9);
            rates[r] = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd8191 :
                       pcc_pkg::RATE_W'($urandom_range(1500, 8191));
            lens[r]  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
         end
         apply_config(rates[0], rates[1], rates[2], pcc_pkg::SLOTS_W'($urandom),
                      pcc_pkg::SLOTS_W'($urandom), pcc_pkg::SLOTS_W'($urandom),
                      pack_lengths(lens[0], lens[1], lens[2]));
         // Each phase picks its own pacing; a zero gives a stretch with no idling.
         pick = $urandom_range(0, 2);
         req_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
         pick = $urandom_range(0, 2);
         rsp_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
         phase_items = $urandom_range(20, 50);
         if (phase_items > stop_at - items_sent)
            phase_items = stop_at - items_sent;
         repeat (phase_items) begin
            if ($urandom_range(0, 99) < 60)
               send_tick();
            else
               send_write($urandom_range(0, PALETTE_DEPTH - 1), $urandom_range(0, 4095));
         end
      end
      req_idle_pct = 0;
      rsp_idle_pct = 0;
   endtask

   // Receiver: random stalls, or one long hold when a test asks for it.
   initial begin : rsp_side
      int run;
      run = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            run = LONG_HOLD;
         end else if (run == 0) begin
            run = pick_gap(rsp_idle_pct);
         end
         if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every result transfer is matched against the oldest predicted rewrite.
   always @(posedge clock) begin : check_rewrites
      pcc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_payload);
            mismatches++;
         end else begin
            want = expected_writes.pop_front();
            if (rsp_payload.color_register !== want.color_register) begin
               $error("color_register: expected %0d, got %0d",
                      want.color_register, rsp_payload.color_register);
               mismatches++;
            end
            if (rsp_payload.color_value !== want.color_value) begin
               $error("color_value: expected %h, got %h",
                      want.color_value, rsp_payload.color_value);
               mismatches++;
            end
            if (rsp_payload.range_number !== want.range_number) begin
               $error("range_number: expected %0d, got %0d",
                      want.range_number, rsp_payload.range_number);
               mismatches++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_payload.last);
               mismatches++;
            end
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rate_cfg  = '{pcc_pkg::PCC_RATE0_RESET, pcc_pkg::PCC_RATE1_RESET,
                    pcc_pkg::PCC_RATE2_RESET};
      slots_cfg = '{pcc_pkg::PCC_SLOTS0_RESET, pcc_pkg::PCC_SLOTS1_RESET,
                    pcc_pkg::PCC_SLOTS2_RESET};
      lens_cfg  = pcc_pkg::PCC_LENS_RESET;
      step_acc  = '{default: '0};
      head_pos  = '{default: '0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_palette_fill();
      test_special_cases();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      if (mismatches == 0 && expected_writes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
